// ===== src/postings_varint_delta_decoder_defines.svh =====
// assertion macros shared by the postings decoder modules
`ifndef POSTINGS_VARINT_DELTA_DECODER_DEFINES_SVH
`define POSTINGS_VARINT_DELTA_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PVDD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PVDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pvdd_pkg.sv =====
// shared types and constants for the postings decoder
`timescale 1ns / 1ps
`default_nettype none

package pvdd_pkg;

  // default accumulator width
  localparam int DEFAULT_VALUE_WIDTH = 32;

  // widths of the fixed request fields
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 32;

  // reset value of the format register: varint delta coding
  localparam logic COMPRESSED_RESET = 1'b1;

  // flags of one event passed from the byte front end to the posting back end
  typedef struct packed {
    logic start;  // list begins on this byte, count travels alongside
    logic done;   // a value has been completed
    logic is_tf;  // completed value is the term frequency
    logic delta;  // completed value is delta coded
    logic bad;    // varint ran past its maximum length
  } evt_t;

  localparam int EVT_W = $bits(evt_t);

endpackage : pvdd_pkg

`default_nettype wire

// ===== src/pvdd_front.sv =====
// byte front end: assembles varint or raw values and emits events
`timescale 1ns / 1ps
`default_nettype none

module pvdd_front #(
  parameter int VALUE_WIDTH = pvdd_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_wr_data,
  input  wire logic                        accept,
  input  wire logic [pvdd_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                        list_start,
  output logic                             push,
  output pvdd_pkg::evt_t                   evt,
  output logic [VALUE_WIDTH-1:0]           value
);

  localparam int VARINT_MAX = (VALUE_WIDTH + 6) / 7;
  localparam int RAW_BYTES  = (VALUE_WIDTH + 7) / 8;
  localparam int POS_MAX    = (VARINT_MAX > RAW_BYTES) ? VARINT_MAX : RAW_BYTES;
  localparam int POS_W      = (POS_MAX > 2) ? $clog2(POS_MAX) : 1;
  localparam int SH_W       = 8;

  logic                   compressed_r, compressed_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   phase_r, phase_nxt;

  logic [VALUE_WIDTH-1:0] base_acc;
  logic [POS_W-1:0]       base_pos;
  logic                   base_phase;
  logic [POS_W:0]         pos_inc;
  logic [SH_W-1:0]        shamt;
  logic [VALUE_WIDTH-1:0] group_ext;
  logic [VALUE_WIDTH-1:0] acc_new;
  logic                   done;
  logic                   bad;

  // format register
  always_comb begin
    compressed_nxt = cfg_wr_en ? cfg_wr_data : compressed_r;
  end

  // list start clears the value assembly before the byte is used
  always_comb begin
    base_acc   = list_start ? '0 : acc_r;
    base_pos   = list_start ? '0 : pos_r;
    base_phase = list_start ? 1'b0 : phase_r;
    pos_inc    = {1'b0, base_pos} + 1'b1;
  end

  // place the byte's group at its position
  always_comb begin
    if (compressed_r) begin
      shamt     = SH_W'(base_pos) * SH_W'(7);
      group_ext = VALUE_WIDTH'(data_byte[6:0]);
    end else begin
      shamt     = SH_W'(base_pos) * SH_W'(8);
      group_ext = VALUE_WIDTH'(data_byte);
    end
    acc_new = base_acc | (group_ext << shamt);
  end

  // completion and overflow detection
  always_comb begin
    done = 1'b0;
    bad  = 1'b0;
    if (compressed_r) begin
      if (!data_byte[7]) begin
        done = 1'b1;
      end else if (pos_inc >= (POS_W + 1)'(VARINT_MAX)) begin
        bad = 1'b1;
      end
    end else if (pos_inc >= (POS_W + 1)'(RAW_BYTES)) begin
      done = 1'b1;
    end
  end

  // next assembly state
  always_comb begin
    if (done) begin
      acc_nxt   = '0;
      pos_nxt   = '0;
      phase_nxt = ~base_phase;
    end else if (bad) begin
      acc_nxt   = '0;
      pos_nxt   = '0;
      phase_nxt = 1'b0;
    end else begin
      acc_nxt   = acc_new;
      pos_nxt   = pos_inc[POS_W-1:0];
      phase_nxt = base_phase;
    end
  end

  // event toward the back end
  always_comb begin
    evt.start = list_start;
    evt.done  = done;
    evt.is_tf = base_phase;
    evt.delta = compressed_r;
    evt.bad   = bad;
    value     = acc_new;
    push      = accept && (list_start || done || bad);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compressed_r <= pvdd_pkg::COMPRESSED_RESET;
      acc_r        <= '0;
      pos_r        <= '0;
      phase_r      <= 1'b0;
    end else begin
      compressed_r <= compressed_nxt;
      if (accept) begin
        acc_r   <= acc_nxt;
        pos_r   <= pos_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

endmodule : pvdd_front

`default_nettype wire

// ===== src/pvdd_queue.sv =====
// two-entry event queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none

`include "postings_varint_delta_decoder_defines.svh"

module pvdd_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty,
  output logic                  full
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  // status and head entry
  always_comb begin
    not_empty = (cnt_r != 2'd0);
    full      = (cnt_r == 2'd2);
    pop_data  = slot_r[rd_ptr_r];
  end

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `PVDD_ASSERT_NOW(a_no_overflow, clk, rst_n, push && !pop, cnt_r != 2'd2, "queue overflow")
  `PVDD_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, cnt_r != 2'd0, "queue underflow")

endmodule : pvdd_queue

`default_nettype wire

// ===== src/pvdd_back.sv =====
// posting back end: delta add, pairing, count tracking, result register
`timescale 1ns / 1ps
`default_nettype none

`include "postings_varint_delta_decoder_defines.svh"

module pvdd_back #(
  parameter int VALUE_WIDTH = pvdd_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         evt_valid,
  input  wire pvdd_pkg::evt_t               evt,
  input  wire logic [VALUE_WIDTH-1:0]       value,
  input  wire logic [pvdd_pkg::COUNT_W-1:0] count,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [pvdd_pkg::FIELD_W-1:0]      out_doc_id,
  output logic [pvdd_pkg::FIELD_W-1:0]      out_term_freq,
  output logic                              out_last_posting,
  output logic                              out_malformed
);

  localparam int FW = pvdd_pkg::FIELD_W;
  localparam int CW = pvdd_pkg::COUNT_W;

  logic [VALUE_WIDTH-1:0] prev_r, prev_nxt;
  logic [VALUE_WIDTH-1:0] pend_r, pend_nxt;
  logic [CW-1:0]          left_r, left_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [FW-1:0]          doc_r, doc_nxt;
  logic [FW-1:0]          tf_r, tf_nxt;
  logic                   last_r, last_nxt;
  logic                   bad_r, bad_nxt;

  logic [VALUE_WIDTH-1:0] prev_base;
  logic [VALUE_WIDTH-1:0] pend_base;
  logic [CW-1:0]          left_base;
  logic                   load;

  // take an event whenever the result register can be refilled
  always_comb begin
    pop  = evt_valid && (!out_valid_r || !out_stall);
    load = pop && (evt.bad || (evt.done && evt.is_tf));
  end

  // list start takes effect before the value
  always_comb begin
    prev_base = evt.start ? '0 : prev_r;
    pend_base = evt.start ? '0 : pend_r;
    left_base = evt.start ? count : left_r;
  end

  // list state and result fields
  always_comb begin
    prev_nxt = prev_base;
    pend_nxt = pend_base;
    left_nxt = left_base;
    doc_nxt  = FW'(pend_base);
    tf_nxt   = FW'(value);
    last_nxt = (left_base == CW'(1));
    bad_nxt  = 1'b0;
    if (evt.bad) begin
      prev_nxt = '0;
      pend_nxt = '0;
      left_nxt = '0;
      doc_nxt  = '0;
      tf_nxt   = '0;
      last_nxt = 1'b0;
      bad_nxt  = 1'b1;
    end else if (evt.done && !evt.is_tf) begin
      pend_nxt = evt.delta ? (prev_base + value) : value;
    end else if (evt.done) begin
      if (evt.delta) begin
        prev_nxt = pend_base;
      end
      if (left_base != '0) begin
        left_nxt = left_base - CW'(1);
      end
    end
  end

  // result valid
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      pend_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        prev_r <= prev_nxt;
        pend_r <= pend_nxt;
        left_r <= left_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      doc_r  <= doc_nxt;
      tf_r   <= tf_nxt;
      last_r <= last_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_doc_id       = doc_r;
  assign out_term_freq    = tf_r;
  assign out_last_posting = last_r;
  assign out_malformed    = bad_r;

  `PVDD_ASSERT_NOW(a_bad_fields_zero, clk, rst_n, out_valid_r && bad_r, doc_r == '0 && tf_r == '0 && !last_r, "malformed result carries data")
  `PVDD_ASSERT_NEXT(a_bad_clears_left, clk, rst_n, pop && evt.bad, left_r == '0 && prev_r == '0, "malformed event left list state")
  `PVDD_ASSERT_NEXT(a_last_empties, clk, rst_n, load && last_nxt, left_r == '0, "last posting left count nonzero")

endmodule : pvdd_back

`default_nettype wire

// ===== src/postings_varint_delta_decoder.sv =====
// top level of the posting list decoder: front end, event queue, back end
//
//   channel | direction | handshake        | payload
//   in_     | in        | in_valid/in_stall | data_byte, list_start, posting_count
//   out_    | out       | out_valid/out_stall | doc_id, term_freq, last_posting, malformed
//   cfg_    | in        | cfg_wr_en         | cfg_wr_data (compressed_format)
//
// one byte per cycle is accepted while in_stall is low; the front end adds each byte to its value combinationally
// a posting passes from the event queue into the result register; out_stall can hold it in the queue
// in_stall is high only while the two-entry event queue is full
// reset is synchronous and active low; no clearing pass is needed
// out_stall backs up the queue, the front end keeps taking bytes until it fills
`timescale 1ns / 1ps
`default_nettype none

module postings_varint_delta_decoder #(
  parameter int VALUE_WIDTH = pvdd_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pvdd_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic                         in_list_start,
  input  wire logic [pvdd_pkg::COUNT_W-1:0] in_posting_count,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [pvdd_pkg::FIELD_W-1:0]      out_doc_id,
  output logic [pvdd_pkg::FIELD_W-1:0]      out_term_freq,
  output logic                              out_last_posting,
  output logic                              out_malformed
);

  localparam int QW = pvdd_pkg::EVT_W + pvdd_pkg::COUNT_W + VALUE_WIDTH;

  logic                            accept;
  logic                            push;
  pvdd_pkg::evt_t                  f_evt;
  logic [VALUE_WIDTH-1:0]          f_value;
  logic [QW-1:0]                   q_in;
  logic [QW-1:0]                   q_out;
  logic                            q_not_empty;
  logic                            q_full;
  logic                            pop;
  pvdd_pkg::evt_t                  b_evt;
  logic [VALUE_WIDTH-1:0]          b_value;
  logic [pvdd_pkg::COUNT_W-1:0]    b_count;

  // request handshake
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  pvdd_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .list_start  (in_list_start),
    .push        (push),
    .evt         (f_evt),
    .value       (f_value)
  );

  // pack and unpack queue entries
  assign q_in = {f_evt, in_posting_count, f_value};
  assign {b_evt, b_count, b_value} = q_out;

  pvdd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_in),
    .pop       (pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  pvdd_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .evt_valid        (q_not_empty),
    .evt              (b_evt),
    .value            (b_value),
    .count            (b_count),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_doc_id       (out_doc_id),
    .out_term_freq    (out_term_freq),
    .out_last_posting (out_last_posting),
    .out_malformed    (out_malformed)
  );

endmodule : postings_varint_delta_decoder

`default_nettype wire

// ===== test/tb.sv =====
// testbench for the posting list decoder: directed table, random lists, checked by a predictor
`timescale 1ns / 1ps

module tb;

  localparam int VARINT_MAX = 5;  // longest legal varint at 32 bits
  localparam int RAW_BYTES  = 4;  // bytes per raw little-endian word
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 800;

  // one request on the byte channel
  typedef struct packed {
    logic [pvdd_pkg::BYTE_W-1:0]  data;
    logic                         start;
    logic [pvdd_pkg::COUNT_W-1:0] count;
  } req_t;

  // one posting on the result channel
  typedef struct packed {
    logic [pvdd_pkg::FIELD_W-1:0] doc_id;
    logic [pvdd_pkg::FIELD_W-1:0] term_freq;
    logic                         last_posting;
    logic                         malformed;
  } posting_t;

  // directed row: format, request, and a typed posting where chk is set
  typedef struct packed {
    logic                         fmt;
    logic [pvdd_pkg::BYTE_W-1:0]  data;
    logic                         start;
    logic [pvdd_pkg::COUNT_W-1:0] count;
    logic                         chk;
    posting_t                     want;
  } row_t;

  localparam posting_t NONE = '0;

  localparam row_t DIR_ROWS [23] = '{
    // list of two, zero delta then term frequency 5
    '{1'b1, 8'h00, 1'b1, 32'd2, 1'b0, NONE},
    '{1'b1, 8'h05, 1'b0, 32'd0, 1'b1, '{32'h0, 32'd5, 1'b0, 1'b0}},
    // five-byte delta whose top group overflows 32 bits
    '{1'b1, 8'hFF, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b1, 8'hFF, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b1, 8'hFF, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b1, 8'hFF, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b1, 8'h7F, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b1, 8'h7F, 1'b0, 32'd0, 1'b1, '{32'hFFFF_FFFF, 32'h7F, 1'b1, 1'b0}},
    // overlong varint
    '{1'b1, 8'h80, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b1, 8'h80, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b1, 8'h80, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b1, 8'h80, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b1, 8'h80, 1'b0, 32'd0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b1}},
    // count of zero never marks a last posting
    '{1'b1, 8'h03, 1'b1, 32'd0, 1'b0, NONE},
    '{1'b1, 8'h02, 1'b0, 32'd0, 1'b1, '{32'd3, 32'd2, 1'b0, 1'b0}},
    // raw pair under the largest count
    '{1'b0, 8'h78, 1'b1, 32'hFFFF_FFFF, 1'b0, NONE},
    '{1'b0, 8'h56, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b0, 8'h34, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b0, 8'h12, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b0, 8'hFF, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b0, 8'hFF, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b0, 8'hFF, 1'b0, 32'd0, 1'b0, NONE},
    '{1'b0, 8'hFF, 1'b0, 32'd0, 1'b1, '{32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 1'b0}}
  };

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic                         cfg_wr_data = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [pvdd_pkg::BYTE_W-1:0]  in_data_byte = '0;
  logic                         in_list_start = 1'b0;
  logic [pvdd_pkg::COUNT_W-1:0] in_posting_count = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [pvdd_pkg::FIELD_W-1:0] out_doc_id;
  logic [pvdd_pkg::FIELD_W-1:0] out_term_freq;
  logic                         out_last_posting;
  logic                         out_malformed;

  postings_varint_delta_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_list_start    (in_list_start),
    .in_posting_count (in_posting_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_doc_id       (out_doc_id),
    .out_term_freq    (out_term_freq),
    .out_last_posting (out_last_posting),
    .out_malformed    (out_malformed)
  );

  // decoder state mirrored by the predictor
  logic                         fmt_compressed = pvdd_pkg::COMPRESSED_RESET;
  logic [pvdd_pkg::FIELD_W-1:0] acc = '0;
  logic [2:0]                   pos = '0;
  logic                         expect_tf = 1'b0;
  logic [pvdd_pkg::FIELD_W-1:0] pend_doc = '0;
  logic [pvdd_pkg::FIELD_W-1:0] prev_doc = '0;
  logic [pvdd_pkg::COUNT_W-1:0] postings_left = '0;

  posting_t posting_q [$];  // postings still owed by the decoder
  req_t     list_q [$];     // bytes of the list being sent
  int       errors = 0;
  int       cycles = 0;
  int       bytes_sent = 0;
  bit       in_quiet = 1'b0;
  bit       out_quiet = 1'b0;
  posting_t got_want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void clear_list_state();
    acc = '0;
    pos = '0;
    expect_tf = 1'b0;
    pend_doc = '0;
    prev_doc = '0;
  endfunction

  // predict the posting, if any, that one accepted byte produces
  function automatic bit decode_byte(input req_t r, output posting_t p);
    logic [63:0]                  shifted;
    logic [pvdd_pkg::FIELD_W-1:0] value;
    p = '0;
    if (r.start) begin
      clear_list_state();
      postings_left = r.count;
    end
    if (fmt_compressed) begin
      shifted = {57'd0, r.data[6:0]} << (7 * pos);
      acc = acc | shifted[pvdd_pkg::FIELD_W-1:0];
      if (r.data[7]) begin
        if (pos + 1 >= VARINT_MAX) begin
          // overlong varint: list state dropped, flagged posting
          clear_list_state();
          postings_left = '0;
          p.malformed = 1'b1;
          return 1'b1;
        end
        pos = pos + 1'b1;
        return 1'b0;
      end
    end else begin
      shifted = {56'd0, r.data} << (8 * pos);
      acc = acc | shifted[pvdd_pkg::FIELD_W-1:0];
      if (pos + 1 < RAW_BYTES) begin
        pos = pos + 1'b1;
        return 1'b0;
      end
    end
    // a value is complete
    value = acc;
    acc = '0;
    pos = '0;
    if (!expect_tf) begin
      pend_doc = fmt_compressed ? prev_doc + value : value;
      expect_tf = 1'b1;
      return 1'b0;
    end
    expect_tf = 1'b0;
    if (fmt_compressed) prev_doc = pend_doc;
    p.doc_id = pend_doc;
    p.term_freq = value;
    p.last_posting = (postings_left == 1);
    if (postings_left != 0) postings_left = postings_left - 1'b1;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result check against the oldest owed posting
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (posting_q.size() == 0) begin
        $display("%0t: posting expected none actual %h %h %b %b", $time, out_doc_id,
                 out_term_freq, out_last_posting, out_malformed);
        errors++;
      end else begin
        got_want = posting_q.pop_front();
        check_field("doc_id", got_want.doc_id, out_doc_id);
        check_field("term_freq", got_want.term_freq, out_term_freq);
        check_field("last_posting", 32'(got_want.last_posting), 32'(out_last_posting));
        check_field("malformed", 32'(got_want.malformed), 32'(out_malformed));
      end
    end
  end

  // receiver: random stall per posting; long ones after 40 and at random back up the decoder
  initial begin : receiver
    int hold;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 40 || $urandom_range(0, 299) == 0) hold = 80;
      else if (out_quiet) hold = 0;
      else hold = $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // offer one request after a random gap; predict once it is taken
  task automatic send_request(input req_t r, input logic chk, input posting_t want);
    int       gap;
    posting_t p;
    bit       got;
    gap = in_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= r.data;
    in_list_start <= r.start;
    in_posting_count <= r.count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = decode_byte(r, p);
    if (chk) posting_q.insert(posting_q.size(), want);
    else if (got) posting_q.insert(posting_q.size(), p);
    bytes_sent++;
  endtask

  // format change only once the decoder has drained
  task automatic set_format(input logic fmt);
    in_valid <= 1'b0;
    while (posting_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fmt_compressed = fmt;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(0, 127);
      2: return $urandom_range(128, 20000);
      3: return $urandom;
      4: return 32'hFFFF_FFFF;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic void put_byte(input logic [7:0] d);
    list_q.insert(list_q.size(), req_t'{d, 1'b0, 32'd0});
  endfunction

  // LEB128; padded form always takes five bytes with junk above bit 31
  function automatic void put_varint(input logic [31:0] v, input bit padded);
    int k;
    if (padded) begin
      for (k = 0; k < 4; k++) put_byte({1'b1, v[7*k +: 7]});
      put_byte({1'b0, 3'($urandom), v[31:28]});
    end else begin
      while (v >= 128) begin
        put_byte({1'b1, v[6:0]});
        v = v >> 7;
      end
      put_byte({1'b0, v[6:0]});
    end
  endfunction

  function automatic void put_word(input logic [31:0] v);
    int k;
    for (k = 0; k < RAW_BYTES; k++) put_byte(v[8*k +: 8]);
  endfunction

  // one list in the current format, or loose noise bytes
  function automatic void build_list();
    int                           first;
    int                           n;
    int                           k;
    logic [pvdd_pkg::COUNT_W-1:0] cnt;
    first = list_q.size();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++)
        list_q.insert(list_q.size(),
                      req_t'{8'($urandom), $urandom_range(0, 3) == 0, 32'($urandom)});
      return;
    end
    cnt = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 6));
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      if (fmt_compressed) begin
        if ($urandom_range(0, 24) == 0) begin
          // overlong delta
          repeat (VARINT_MAX) put_byte({1'b1, 7'($urandom)});
        end else begin
          put_varint(pick_value(), $urandom_range(0, 14) == 0);
        end
        put_varint(pick_value(), $urandom_range(0, 14) == 0);
      end else begin
        put_word(pick_value());
        put_word(pick_value());
      end
    end
    // sometimes cut the list short
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) if (list_q.size() > first + 1) void'(list_q.pop_back());
    list_q[first].start = 1'b1;
    list_q[first].count = cnt;
  endfunction

  // stimulus
  initial begin : stimulus
    int   phase;
    int   target;
    logic fmt;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    set_format(DIR_ROWS[0].fmt);
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].fmt != fmt_compressed) set_format(DIR_ROWS[i].fmt);
      send_request(req_t'{DIR_ROWS[i].data, DIR_ROWS[i].start, DIR_ROWS[i].count},
                   DIR_ROWS[i].chk, DIR_ROWS[i].want);
    end

    // random phases, each under one format
    for (phase = 0; bytes_sent < RANDOM_BYTES + $size(DIR_ROWS); phase++) begin
      fmt = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      set_format(fmt);
      target = bytes_sent + $urandom_range(60, 140);
      while (bytes_sent < target) begin
        build_list();
        while (list_q.size() != 0) send_request(list_q.pop_front(), 1'b0, NONE);
      end
    end

    // drain and finish
    in_valid <= 1'b0;
    while (posting_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
